// ----- rtl/tif_pkg.sv -----
// Shared types and constants for the telnet IAC filter.
// Used by the parser, the result FIFO and the top level; depends on nothing else.
package tif_pkg;

	localparam logic [7:0] B_IAC  = 8'd255;
	localparam logic [7:0] B_DONT = 8'd254;
	localparam logic [7:0] B_DO   = 8'd253;
	localparam logic [7:0] B_WONT = 8'd252;
	localparam logic [7:0] B_WILL = 8'd251;
	localparam logic [7:0] B_SB   = 8'd250;
	localparam logic [7:0] B_SE   = 8'd240;

	localparam logic [7:0] TRACKED_OPTION_RESET = 8'd201;

	// Result FIFO depth: a power of two, at least two.
	localparam int TIF_FIFO_DEPTH = 4;

	typedef enum logic [2:0] {
		PH_TEXT    = 3'd0,
		PH_IAC     = 3'd1,
		PH_NEG     = 3'd2,
		PH_SBOPT   = 3'd3,
		PH_BODY    = 3'd4,
		PH_BODYIAC = 3'd5,
		PH_OPTIAC  = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		KIND_TEXT = 2'd0,
		KIND_PAY  = 2'd1,
		KIND_END  = 2'd2
	} kind_t;

	typedef struct packed {
		phase_t phase;
		logic   neg_enables;
		logic   body_tracked;
		logic   enabled;
	} parse_state_t;

	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
		logic       enabled;
		logic       last;
	} result_t;

	// Up to two results caused by one received byte, r0 first.
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} result_pair_t;

endpackage

// ----- rtl/tif_parser.sv -----
// Combinational telnet parse step: next parse state and results for one byte.
// Depends on tif_pkg.
module tif_parser
	import tif_pkg::*;
(
	input  parse_state_t cur,
	input  logic [7:0]   in_byte,
	input  logic [7:0]   tracked_option,
	output parse_state_t nxt,
	output result_pair_t res
);

	logic body_iac;
	logic emit_iac;
	logic emit_byte;

	always_comb begin
		nxt       = cur;
		res       = '0;
		body_iac  = (cur.phase == PH_BODYIAC);
		emit_iac  = 1'b0;
		emit_byte = 1'b0;

		case (cur.phase)
			PH_IAC: begin
				if (in_byte == B_IAC) begin
					res.n       = 2'd1;
					res.r0.data = B_IAC;
					res.r0.kind = KIND_TEXT;
					nxt.phase   = PH_TEXT;
				end else if (in_byte == B_WILL || in_byte == B_WONT ||
				             in_byte == B_DO || in_byte == B_DONT) begin
					nxt.neg_enables = (in_byte == B_DO || in_byte == B_WILL);
					nxt.phase       = PH_NEG;
				end else if (in_byte == B_SB) begin
					nxt.phase = PH_SBOPT;
				end else begin
					nxt.phase = PH_TEXT;
				end
			end
			PH_NEG: begin
				if (in_byte == tracked_option) begin
					nxt.enabled = cur.neg_enables;
				end
				nxt.phase = PH_TEXT;
			end
			PH_SBOPT: begin
				nxt.body_tracked = (in_byte == tracked_option);
				nxt.phase        = (in_byte == B_IAC) ? PH_OPTIAC : PH_BODY;
			end
			PH_BODY: begin
				if (in_byte == B_IAC) begin
					nxt.phase = PH_BODYIAC;
				end else if (cur.body_tracked) begin
					res.n       = 2'd1;
					res.r0.data = in_byte;
					res.r0.kind = KIND_PAY;
				end
			end
			PH_BODYIAC, PH_OPTIAC: begin
				if (in_byte == B_SE) begin
					if (cur.body_tracked && body_iac) begin
						res.n       = 2'd1;
						res.r0.data = 8'd0;
						res.r0.kind = KIND_END;
					end
					nxt.phase        = PH_TEXT;
					nxt.body_tracked = 1'b0;
				end else begin
					// A pending IAC that is not closed by SE is body data.
					emit_iac  = cur.body_tracked && body_iac;
					emit_byte = cur.body_tracked && (in_byte != B_IAC);
					nxt.phase = (in_byte == B_IAC) ? PH_BODYIAC : PH_BODY;
					if (emit_iac) begin
						res.r0.data = B_IAC;
						res.r0.kind = KIND_PAY;
						if (emit_byte) begin
							res.n       = 2'd2;
							res.r1.data = in_byte;
							res.r1.kind = KIND_PAY;
						end else begin
							res.n = 2'd1;
						end
					end else if (emit_byte) begin
						res.n       = 2'd1;
						res.r0.data = in_byte;
						res.r0.kind = KIND_PAY;
					end
				end
			end
			default: begin
				// Plain text, and the unused phase code as well.
				if (in_byte == B_IAC) begin
					nxt.phase = PH_IAC;
				end else begin
					nxt.phase   = PH_TEXT;
					res.n       = 2'd1;
					res.r0.data = in_byte;
					res.r0.kind = KIND_TEXT;
				end
			end
		endcase

		res.r0.enabled = nxt.enabled;
		res.r1.enabled = nxt.enabled;
		res.r0.last    = (res.n == 2'd1);
		res.r1.last    = 1'b1;
	end

endmodule

// ----- rtl/tif_out_fifo.sv -----
// Result FIFO: takes up to two results per cycle and releases one per cycle while it is popped.
// Depends on tif_pkg.
module tif_out_fifo
	import tif_pkg::*;
#(
	parameter int DEPTH = TIF_FIFO_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  result_pair_t push,
	input  logic         pop,
	output logic         room,
	output logic         not_empty,
	output result_t      head
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	result_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign not_empty = (count_q != '0);
	// Room for a full pair whatever happens on the read side.
	assign room      = (count_q <= CNT_W'(DEPTH - 2));
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr_q + PTR_W'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push.n) - CNT_W'(pop);
		end
	end

endmodule

// ----- rtl/telnet_iac_filter_top.sv -----
// Telnet IAC filter, top level: input register, parse step, result FIFO.
// An accepted byte waits in the input register until the result FIFO has room.
// Throughput: one byte per cycle while the result FIFO has room for a pair;
// the single-result output port of the result FIFO shows one result at a time.
// Reset (arst_n, asynchronous, active low) empties the pipeline, returns the
// parser to plain text with the option disabled and sets tracked_option to 201.
module telnet_iac_filter_top
	import tif_pkg::*;
#(
	parameter int FIFO_DEPTH = TIF_FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// Received byte stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	// Filtered result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [8] option_enabled, [15:9] zero
	output logic [1:0]  m_tuser,   // [1:0] out_kind
	output logic        m_tlast,   // last result caused by one received byte
	// Configuration write channel for tracked_option.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	logic [7:0]   byte_s1;
	logic         valid_s1;
	logic [7:0]   tracked_q;
	parse_state_t state_q;
	parse_state_t state_nxt;
	result_pair_t parsed;
	result_pair_t push;
	result_t      head;
	logic         room;
	logic         consume;
	logic         pop;

	// The configuration register is always ready and not guarded by the block:
	// the user must write it only while idle, so no transaction in flight sees a change.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracked_q <= TRACKED_OPTION_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tracked_q <= cfg_data;
		end
	end

	// The registered byte is parsed and retired once the FIFO can take a full
	// pair of results. A new transaction is taken whenever the stage is empty
	// or drains in the same cycle.
	assign consume  = valid_s1 && room;
	assign s_tready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	tif_parser u_parser (
		.cur            (state_q),
		.in_byte        (byte_s1),
		.tracked_option (tracked_q),
		.nxt            (state_nxt),
		.res            (parsed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_TEXT, neg_enables: 1'b0, body_tracked: 1'b0,
			             enabled: 1'b0};
		end else if (consume) begin
			state_q <= state_nxt;
		end
	end

	// Nothing is written into the FIFO unless the byte is really retired.
	always_comb begin
		push = parsed;
		if (!consume) begin
			push.n = 2'd0;
		end
	end

	assign pop = m_tvalid && m_tready;

	tif_out_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.room      (room),
		.not_empty (m_tvalid),
		.head      (head)
	);

	assign m_tdata = {7'd0, head.enabled, head.data};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

	// A retired byte with results makes them visible on the next cycle.
	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |=> m_tvalid)
		else $error("results pushed but output not valid");

	// A byte held back for lack of room stays in the stage unchanged.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !room) |=> (valid_s1 && $stable(byte_s1)))
		else $error("stalled byte lost or altered");

	// In a pair only the second result carries the last mark.
	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n == 2'd2) |-> (!push.r0.last && push.r1.last))
		else $error("wrong last marking in result pair");

	// Parser state moves only when a byte is retired.
	a_state_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!consume |=> $stable(state_q))
		else $error("parse state changed without a byte");

endmodule
